// ===== src/mms_pkg.sv =====
// Shared types, command and opcode codes, and elaboration helpers for the step core.
package mms_pkg;

    localparam int NUM_REGS = 8;
    localparam int RF_AW    = 3;
    localparam int WORD_W   = 32;
    localparam int PC_W     = 12;
    localparam int INSTR_W  = 16;

    // Command codes carried on the request side.
    localparam logic [2:0] CMD_STEP     = 3'd0;
    localparam logic [2:0] CMD_WR_PROG  = 3'd1;
    localparam logic [2:0] CMD_WR_DATA  = 3'd2;
    localparam logic [2:0] CMD_BACK     = 3'd3;
    localparam logic [2:0] CMD_PC_RESET = 3'd4;

    // Opcodes.
    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_JUMP  = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    // R-type function codes.
    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd2;
    localparam logic [2:0] FN_AND = 3'd4;
    localparam logic [2:0] FN_OR  = 3'd5;

    // Instruction word; low holds rd and funct for R-type, or the immediate.
    typedef struct packed {
        logic [3:0] opcode;
        logic [2:0] rs;
        logic [2:0] rt;
        logic [5:0] low;
    } instr_t;

    // Register file write request.
    typedef struct packed {
        logic              en;
        logic [RF_AW-1:0]  addr;
        logic [WORD_W-1:0] data;
    } rf_wr_t;

    // Result of one request; step_done sits in the lowest bit.
    typedef struct packed {
        logic [WORD_W-1:0] mem_value;
        logic [7:0]        mem_address;
        logic              mem_written;
        logic [WORD_W-1:0] reg_value;
        logic [2:0]        reg_index;
        logic              reg_written;
        logic [3:0]        opcode_run;
        logic [PC_W-1:0]   pc_now;
        logic              end_of_program;
        logic              step_done;
    } result_t;

    function automatic bit is_pow2(input int depth);
        return (depth & (depth - 1)) == 0;
    endfunction

    // Cycles the data address reduction needs beyond the execute cycle.
    function automatic int ea_latency(input int depth);
        return is_pow2(depth) ? 0 : 3;
    endfunction

endpackage

// ===== src/mini_mips16_step_core_top.sv =====
// Top level of the 16-bit step core: request decode, execute, writeback and result register.
//
// Each request on the slave side is one command (step one instruction, write a program
// word, write a data word, step back to the pc of the last executed instruction, or clear
// the pc) and produces exactly one result on the master side. Most state lives in three
// memories: the program store (never cleared, so only written words may be executed), the
// data memory and the eight-entry register file (both read as zero until written). A
// request passes three stages: at acceptance the register file is read with the rs and rt
// fields of the instruction already fetched for the current pc; in the execute stage the
// ALU, branch compare and data address run, the pc moves, stores and data writes land and
// a load reads the data memory; in the writeback stage the register file is written and
// the result enters the output register. The program store is read at the next pc in the
// same edge that updates the pc, so the following request can be taken once that read has
// returned; with a non-power-of-two DATA_DEPTH the execute stage also waits for the modulo
// reduction of the data address. This fetch loop, pc to program store to register file
// read, sets the rate. A new request can enter while the one before it is still in the
// writeback stage. While a result waits in the output register the block takes one more
// request, which then waits in the writeback stage; after that the slave side holds tready
// low until the master side drains. The user must write program_length through cfg_wr_en
// and cfg_wr_data only while no request is in flight; the block does not enforce this.
// There is no clearing pass after reset.
module mini_mips16_step_core_top #(
    parameter int PROG_DEPTH = 128,
    parameter int DATA_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    input  logic [39:0] s_axis_tdata,   // [7:0] address, [39:8] value
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] step_done, [1] end_of_program, [13:2] pc_now, [17:14] opcode_run,
    // [18] reg_written, [21:19] reg_index, [53:22] reg_value, [54] mem_written,
    // [62:55] mem_address, [94:63] mem_value, [95] zero
    output logic [95:0] m_axis_tdata,
    // program_length register.
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import mms_pkg::*;

    localparam int PA_W   = $clog2(PROG_DEPTH);
    localparam int DA_W   = $clog2(DATA_DEPTH);
    localparam int EA_LAT = ea_latency(DATA_DEPTH);
    localparam int CNT_W  = (EA_LAT > 0) ? $clog2(EA_LAT + 1) : 1;

    // Architectural state outside the memories.
    logic [7:0]      prog_len_reg;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] prev_pc_reg;
    logic            prev_valid_reg;

    // Execute stage.
    logic             x_valid_reg;
    logic             x_valid_next;
    logic [CNT_W-1:0] x_cnt_reg;
    logic [2:0]       x_cmd_reg;
    logic [7:0]       x_addr_reg;
    logic [WORD_W-1:0] x_value_reg;

    // Writeback stage and output register.
    logic    w_valid_reg;
    logic    w_valid_next;
    result_t w_res_reg;
    logic    w_is_lw_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    // Handshake and stage movement.
    logic s_accept;
    logic x_done;
    logic x_adv;
    logic w_adv;

    // Memory connections.
    instr_t            instr;
    logic [WORD_W-1:0] rs_val;
    logic [WORD_W-1:0] rt_val;
    rf_wr_t            rf_wr;
    logic [WORD_W-1:0] dm_rdata;
    logic [DA_W-1:0]   ea;
    logic [11:0]       prog_wr_addr12;

    // Execute stage decode.
    logic [WORD_W-1:0] ea_sum;
    logic [WORD_W-1:0] alu_out;
    logic [PC_W-1:0]   pc_new;
    logic              at_end;
    logic              x_exec;
    logic              x_is_lw;
    logic              pw_en;
    logic              dm_wr_en;
    logic [DA_W-1:0]   dm_wr_addr;
    logic [WORD_W-1:0] dm_wr_data;
    result_t           x_res;
    result_t           w_final;

    // ------------------------------------------------------------------
    // Handshakes. A request enters only when the execute stage is empty; the
    // writeback stage must be empty or draining in the same edge so that its
    // register write is forwarded into the register file read.
    // ------------------------------------------------------------------
    assign w_adv         = w_valid_reg && (!out_valid_reg || m_axis_tready);
    assign x_done        = (x_cnt_reg == CNT_W'(EA_LAT));
    assign x_adv         = x_valid_reg && x_done && (!w_valid_reg || w_adv);
    assign s_axis_tready = !x_valid_reg && (!w_valid_reg || w_adv);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign x_valid_next   = s_accept || (x_valid_reg && !x_adv);
    assign w_valid_next   = x_adv || (w_valid_reg && !w_adv);
    assign out_valid_next = w_adv || (out_valid_reg && !m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg};

    // ------------------------------------------------------------------
    // Memories.
    // ------------------------------------------------------------------
    assign pc_next        = x_adv ? pc_new : pc_reg;
    assign prog_wr_addr12 = 12'(x_addr_reg);

    // The program store is read at the pc that holds after this edge, so the
    // instruction of the current pc is always waiting when a step arrives.
    mms_prog_mem #(
        .DEPTH (PROG_DEPTH)
    ) u_prog_mem (
        .clk     (clk),
        .wr_en   (x_adv && pw_en),
        .wr_addr (prog_wr_addr12[PA_W-1:0]),
        .wr_data (x_value_reg[INSTR_W-1:0]),
        .rd_addr (pc_next[PA_W-1:0]),
        .rd_data (instr)
    );

    mms_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s_accept),
        .rs_addr (instr.rs),
        .rt_addr (instr.rt),
        .rs_data (rs_val),
        .rt_data (rt_val),
        .wr      (rf_wr)
    );

    mms_ea_unit #(
        .DEPTH (DATA_DEPTH)
    ) u_ea_unit (
        .clk (clk),
        .sum (ea_sum),
        .ea  (ea)
    );

    mms_data_mem #(
        .DEPTH (DATA_DEPTH)
    ) u_data_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (x_adv && dm_wr_en),
        .wr_addr (dm_wr_addr),
        .wr_data (dm_wr_data),
        .rd_en   (x_adv && x_is_lw),
        .rd_addr (ea),
        .rd_data (dm_rdata)
    );

    // ------------------------------------------------------------------
    // Execute stage. The operands and instruction stay stable for the whole
    // stage, so the address reduction pipeline settles before the stage advances.
    // ------------------------------------------------------------------
    assign ea_sum = rs_val + WORD_W'(instr.low);
    assign at_end = (pc_reg >= PC_W'(prog_len_reg))
                 || ({1'b0, pc_reg} >= 13'(PROG_DEPTH));

    always_comb
    begin
        case (instr.low[2:0])
            FN_ADD:  alu_out = rs_val + rt_val;
            FN_SUB:  alu_out = rs_val - rt_val;
            FN_AND:  alu_out = rs_val & rt_val;
            FN_OR:   alu_out = rs_val | rt_val;
            default: alu_out = '0;
        endcase
    end

    always_comb
    begin
        x_res      = '0;
        pc_new     = pc_reg;
        x_exec     = 1'b0;
        x_is_lw    = 1'b0;
        pw_en      = 1'b0;
        dm_wr_en   = 1'b0;
        dm_wr_addr = ea;
        dm_wr_data = rt_val;
        case (x_cmd_reg)
            CMD_STEP:
            begin
                if (at_end)
                begin
                    x_res.end_of_program = 1'b1;
                end
                else
                begin
                    x_exec           = 1'b1;
                    x_res.step_done  = 1'b1;
                    x_res.opcode_run = instr.opcode;
                    pc_new           = pc_reg + 12'd1;
                    case (instr.opcode)
                        OP_RTYPE:
                        begin
                            x_res.reg_written = 1'b1;
                            x_res.reg_index   = instr.low[5:3];
                            x_res.reg_value   = alu_out;
                        end
                        OP_ADDI:
                        begin
                            x_res.reg_written = 1'b1;
                            x_res.reg_index   = instr.rt;
                            x_res.reg_value   = ea_sum;
                        end
                        OP_LW:
                        begin
                            // The loaded word is merged in the writeback stage.
                            x_is_lw           = 1'b1;
                            x_res.reg_written = 1'b1;
                            x_res.reg_index   = instr.rt;
                        end
                        OP_SW:
                        begin
                            dm_wr_en          = 1'b1;
                            x_res.mem_written = 1'b1;
                            x_res.mem_address = 8'(ea);
                            x_res.mem_value   = rt_val;
                        end
                        OP_BEQ:
                        begin
                            if (rs_val == rt_val)
                            begin
                                pc_new = pc_reg + PC_W'(instr.low) + 12'd1;
                            end
                        end
                        OP_JUMP:
                        begin
                            pc_new = {instr.rs, instr.rt, instr.low};
                        end
                        default:
                        begin
                            // Unknown opcodes only advance the pc.
                        end
                    endcase
                end
            end
            CMD_WR_PROG:
            begin
                pw_en = ({5'b0, x_addr_reg} < 13'(PROG_DEPTH));
            end
            CMD_WR_DATA:
            begin
                dm_wr_en   = ({1'b0, x_addr_reg} < 9'(DATA_DEPTH));
                dm_wr_addr = x_addr_reg[DA_W-1:0];
                dm_wr_data = x_value_reg;
            end
            CMD_BACK:
            begin
                if (prev_valid_reg)
                begin
                    pc_new = prev_pc_reg;
                end
            end
            CMD_PC_RESET:
            begin
                pc_new = '0;
            end
            default:
            begin
                // Unused command codes change nothing.
            end
        endcase
        x_res.pc_now = pc_new;
    end

    // ------------------------------------------------------------------
    // Writeback stage: a load takes its word from the data memory read port.
    // ------------------------------------------------------------------
    always_comb
    begin
        w_final = w_res_reg;
        if (w_is_lw_reg)
        begin
            w_final.reg_value = dm_rdata;
        end
    end

    assign rf_wr.en   = w_adv && w_res_reg.reg_written;
    assign rf_wr.addr = w_res_reg.reg_index;
    assign rf_wr.data = w_final.reg_value;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg   <= '0;
            pc_reg         <= '0;
            prev_pc_reg    <= '0;
            prev_valid_reg <= 1'b0;
            x_valid_reg    <= 1'b0;
            x_cnt_reg      <= '0;
            w_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prog_len_reg <= cfg_wr_data;
            end
            pc_reg <= pc_next;
            if (x_adv && x_exec)
            begin
                prev_pc_reg    <= pc_reg;
                prev_valid_reg <= 1'b1;
            end
            if (s_accept)
            begin
                x_cnt_reg <= '0;
            end
            else if (x_valid_reg && !x_done)
            begin
                x_cnt_reg <= x_cnt_reg + 1'b1;
            end
            x_valid_reg   <= x_valid_next;
            w_valid_reg   <= w_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            x_cmd_reg   <= s_axis_tuser;
            x_addr_reg  <= s_axis_tdata[7:0];
            x_value_reg <= s_axis_tdata[39:8];
        end
        if (x_adv)
        begin
            w_res_reg   <= x_res;
            w_is_lw_reg <= x_is_lw;
        end
        if (w_adv)
        begin
            out_res_reg <= w_final;
        end
    end

endmodule

// ===== src/mms_prog_mem.sv =====
// Program store: one write port and one read port with registered, write-through read data.
module mms_prog_mem #(
    parameter int DEPTH = 128
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [mms_pkg::INSTR_W-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output mms_pkg::instr_t            rd_data
);
    import mms_pkg::*;

    logic [INSTR_W-1:0] mem [DEPTH];
    logic [INSTR_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read runs every cycle; a write to the same entry is passed through.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            q_reg <= wr_data;
        end
        else
        begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = instr_t'(q_reg);

endmodule

// ===== src/mms_data_mem.sv =====
// Data memory with per-entry valid bits so that unwritten words read as zero.
module mms_data_mem #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [mms_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [mms_pkg::WORD_W-1:0] rd_data
);
    import mms_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [WORD_W-1:0] q_reg;
    logic              q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

// ===== src/mms_regfile.sv =====
// Register file: two registered read ports, one write port, write-through and zero reset.
module mms_regfile (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [mms_pkg::RF_AW-1:0]  rs_addr,
    input  logic [mms_pkg::RF_AW-1:0]  rt_addr,
    output logic [mms_pkg::WORD_W-1:0] rs_data,
    output logic [mms_pkg::WORD_W-1:0] rt_data,
    input  mms_pkg::rf_wr_t            wr
);
    import mms_pkg::*;

    logic [WORD_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [WORD_W-1:0]   rs_q_reg;
    logic [WORD_W-1:0]   rt_q_reg;
    logic                rs_v_reg;
    logic                rt_v_reg;
    logic                rs_hit;
    logic                rt_hit;

    assign rs_hit = wr.en && (wr.addr == rs_addr);
    assign rt_hit = wr.en && (wr.addr == rt_addr);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rs_q_reg <= rs_hit ? wr.data : mem[rs_addr];
            rt_q_reg <= rt_hit ? wr.data : mem[rt_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rs_v_reg  <= 1'b0;
            rt_v_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rs_v_reg <= rs_hit || valid_reg[rs_addr];
                rt_v_reg <= rt_hit || valid_reg[rt_addr];
            end
        end
    end

    assign rs_data = rs_v_reg ? rs_q_reg : '0;
    assign rt_data = rt_v_reg ? rt_q_reg : '0;

endmodule

// ===== src/mms_ea_unit.sv =====
// Reduces a 32-bit data address sum modulo the data memory depth.
module mms_ea_unit #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic [mms_pkg::WORD_W-1:0] sum,
    output logic [$clog2(DEPTH)-1:0]   ea
);
    import mms_pkg::*;

    localparam int AW = $clog2(DEPTH);

    generate
        if (is_pow2(DEPTH))
        begin : g_mask
            assign ea = sum[AW-1:0];
        end
        else
        begin : g_recip
            // The upper half folds in as hi * (65536 mod DEPTH); the folded value is
            // then divided by multiplying with a reciprocal that is exact below 2**25.
            localparam int          FOLD  = 65536 % DEPTH;
            localparam logic [29:0] RECIP = 30'(((64'd1 << 33) / DEPTH) + 1);

            logic [24:0] fold_reg;
            logic [24:0] hold_reg;
            logic [54:0] prod_reg;
            logic [AW-1:0] ea_reg;
            logic [21:0] quot;
            logic [30:0] qd;
            logic [24:0] rem;
            logic [24:0] rem_fix;

            always_ff @(posedge clk)
            begin
                fold_reg <= (25'(sum[31:16]) * 25'(FOLD)) + 25'(sum[15:0]);
                prod_reg <= 55'(fold_reg) * 55'(RECIP);
                hold_reg <= fold_reg;
                ea_reg   <= rem_fix[AW-1:0];
            end

            always_comb
            begin
                quot    = prod_reg[54:33];
                qd      = 31'(quot) * 31'(DEPTH);
                rem     = hold_reg - qd[24:0];
                rem_fix = (rem >= 25'(DEPTH)) ? (rem - 25'(DEPTH)) : rem;
            end

            assign ea = ea_reg;
        end
    endgenerate

endmodule

// ===== src/mms_checker.sv =====
// Port-level checks for the step core, bound to the top level.
module mms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    import mms_pkg::*;

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One request occupies the execute stage, so two never enter back to back.
    a_no_double_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while the previous one is still executing");

    // Executed ALU, addi and load instructions always report a register write and no memory write.
    a_reg_write_decode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0]
        && (m_axis_tdata[17:14] == OP_RTYPE || m_axis_tdata[17:14] == OP_ADDI
            || m_axis_tdata[17:14] == OP_LW)
        |-> m_axis_tdata[18] && !m_axis_tdata[54])
        else $error("register write missing for a writing instruction");

    // No result can appear in the cycle after reset.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

endmodule

bind mini_mips16_step_core_top mms_checker u_mms_checker (.*);

// ===== dv/mini_mips16_step_core_top_tb.sv =====
// Self-checking testbench for the 16-bit step core: request driver, result checker, scoreboard.
`timescale 1ns / 100ps

module mini_mips16_step_core_top_tb;
    import mms_pkg::*;

    localparam int TB_PROG_DEPTH = 128;
    localparam int TB_DATA_DEPTH = 256;

    // Function code and opcode that the core does not decode.
    localparam logic [2:0] FN_NONE  = 3'd7;
    localparam logic [3:0] OP_SPARE = 4'd1;

    // Command codes that the core ignores.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    // Keeps a private copy of the core state and the results it owes.
    class step_core_scoreboard;
        logic [15:0] program_words [TB_PROG_DEPTH];
        bit          program_loaded [TB_PROG_DEPTH];
        logic [31:0] data_words [TB_DATA_DEPTH];
        logic [31:0] regs [NUM_REGS];
        logic [11:0] pc;
        logic [11:0] last_step_pc;
        bit          last_step_valid;
        logic [7:0]  program_length;
        result_t     pending_results [$];
        int          errors;

        function new();
            foreach (program_words[i])
            begin
                program_words[i]  = '0;
                program_loaded[i] = 1'b0;
            end
            foreach (data_words[i])
                data_words[i] = '0;
            foreach (regs[i])
                regs[i] = '0;
            pc              = '0;
            last_step_pc    = '0;
            last_step_valid = 1'b0;
            program_length  = '0;
            errors          = 0;
        endfunction

        // Applies one accepted request to the state and queues the result it owes.
        function void note_request(logic [2:0] cmd, logic [7:0] addr, logic [31:0] val);
            result_t     res;
            instr_t      ins;
            logic [15:0] word;
            logic [11:0] next_pc;
            logic [31:0] imm;
            logic [31:0] sum;
            logic [7:0]  ea;
            logic [2:0]  rd;
            res = '0;
            case (cmd)
                CMD_STEP:
                begin
                    if (pc >= program_length || pc >= TB_PROG_DEPTH)
                        res.end_of_program = 1'b1;
                    else
                    begin
                        word            = program_words[pc];
                        ins             = instr_t'(word);
                        imm             = {26'b0, ins.low};
                        next_pc         = pc + 12'd1;
                        last_step_pc    = pc;
                        last_step_valid = 1'b1;
                        res.step_done   = 1'b1;
                        res.opcode_run  = ins.opcode;
                        case (ins.opcode)
                            OP_RTYPE:
                            begin
                                rd = ins.low[5:3];
                                case (ins.low[2:0])
                                    FN_ADD:  regs[rd] = regs[ins.rs] + regs[ins.rt];
                                    FN_SUB:  regs[rd] = regs[ins.rs] - regs[ins.rt];
                                    FN_AND:  regs[rd] = regs[ins.rs] & regs[ins.rt];
                                    FN_OR:   regs[rd] = regs[ins.rs] | regs[ins.rt];
                                    default: regs[rd] = '0;
                                endcase
                                res.reg_written = 1'b1;
                                res.reg_index   = rd;
                                res.reg_value   = regs[rd];
                            end
                            OP_ADDI:
                            begin
                                regs[ins.rt]    = regs[ins.rs] + imm;
                                res.reg_written = 1'b1;
                                res.reg_index   = ins.rt;
                                res.reg_value   = regs[ins.rt];
                            end
                            OP_LW:
                            begin
                                sum             = regs[ins.rs] + imm;
                                ea              = 8'(sum % TB_DATA_DEPTH);
                                regs[ins.rt]    = data_words[ea];
                                res.reg_written = 1'b1;
                                res.reg_index   = ins.rt;
                                res.reg_value   = regs[ins.rt];
                            end
                            OP_SW:
                            begin
                                sum             = regs[ins.rs] + imm;
                                ea              = 8'(sum % TB_DATA_DEPTH);
                                data_words[ea]  = regs[ins.rt];
                                res.mem_written = 1'b1;
                                res.mem_address = ea;
                                res.mem_value   = data_words[ea];
                            end
                            OP_BEQ:
                                if (regs[ins.rs] == regs[ins.rt])
                                    next_pc = pc + ins.low + 12'd1;
                            OP_JUMP:
                                next_pc = word[11:0];
                            default: ;
                        endcase
                        pc = next_pc;
                    end
                end
                CMD_WR_PROG:
                    if (addr < TB_PROG_DEPTH)
                    begin
                        program_words[addr]  = val[15:0];
                        program_loaded[addr] = 1'b1;
                    end
                CMD_WR_DATA:
                    data_words[addr] = val;
                CMD_BACK:
                    if (last_step_valid)
                        pc = last_step_pc;
                CMD_PC_RESET:
                    pc = '0;
                default: ;
            endcase
            res.pc_now = pc;
            pending_results.push_back(res);
        endfunction

        function void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v,
                         got_v);
            end
        endfunction

        // Compares one accepted result with the oldest result still owed.
        function void check_result(logic [95:0] data);
            result_t want;
            result_t got;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none owed, expected nothing, actual %h", $time,
                         data);
                return;
            end
            want = pending_results.pop_front();
            got  = result_t'(data[94:0]);
            check_field("step_done", 32'(want.step_done), 32'(got.step_done));
            check_field("end_of_program", 32'(want.end_of_program), 32'(got.end_of_program));
            check_field("pc_now", 32'(want.pc_now), 32'(got.pc_now));
            check_field("opcode_run", 32'(want.opcode_run), 32'(got.opcode_run));
            check_field("reg_written", 32'(want.reg_written), 32'(got.reg_written));
            check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
            check_field("reg_value", want.reg_value, got.reg_value);
            check_field("mem_written", 32'(want.mem_written), 32'(got.mem_written));
            check_field("mem_address", 32'(want.mem_address), 32'(got.mem_address));
            check_field("mem_value", want.mem_value, got.mem_value);
            check_field("padding bit", 32'd0, 32'(data[95]));
        endfunction
    endclass

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_PCT     = 7;
    localparam int RANDOM_ITEMS = 650;
    localparam int PHASE_ITEMS  = 80;
    // Settling time after the last owed result, in clock cycles.
    localparam int DRAIN_GAP    = 8;
    localparam int TIMEOUT_NS   = 10_000_000;

    // Directed program. Words 10 and 11 are skipped by the taken branch at 9.
    localparam logic [15:0] DEMO_PROGRAM [13] = '{
        {OP_ADDI, 3'd0, 3'd1, 6'd63},           // r1 = r0 + largest immediate
        {OP_LW, 3'd1, 3'd2, 6'd63},             // r2 = mem[126], the most negative word
        {OP_RTYPE, 3'd2, 3'd2, 3'd3, FN_ADD},   // r3 = r2 + r2, wraps to zero
        {OP_RTYPE, 3'd3, 3'd1, 3'd4, FN_SUB},   // r4 = 0 - 63, wraps negative
        {OP_RTYPE, 3'd4, 3'd1, 3'd5, FN_NONE},  // undecoded funct writes zero
        {OP_RTYPE, 3'd4, 3'd2, 3'd6, FN_AND},
        {OP_RTYPE, 3'd4, 3'd1, 3'd7, FN_OR},
        {OP_SW, 3'd2, 3'd4, 6'd63},             // address wraps modulo the data depth
        {OP_SPARE, 12'hFFF},                    // unknown opcode only moves the pc
        {OP_BEQ, 3'd3, 3'd5, 6'd2},             // r3 == r5, so the branch is taken
        {OP_SPARE, 12'h000},
        {OP_SPARE, 12'h000},
        {OP_JUMP, 12'hFFF}                      // jump to the top of the pc range
    };

    // program_length for the first random phases; later phases pick small values.
    localparam logic [7:0] PRESET_LENGTHS [6] = '{8'd128, 8'd12, 8'd255, 8'd0, 8'd3, 8'd40};

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser  = '0;   // [2:0] command
    logic [39:0] s_axis_tdata  = '0;   // [7:0] address, [39:8] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] step_done, [1] end_of_program, [13:2] pc_now, [17:14] opcode_run,
    // [18] reg_written, [21:19] reg_index, [53:22] reg_value, [54] mem_written,
    // [62:55] mem_address, [94:63] mem_value, [95] zero
    logic [95:0] m_axis_tdata;
    logic        cfg_wr_en     = 1'b0;
    logic [7:0]  cfg_wr_data   = '0;

    // When set, neither side inserts idle cycles.
    bit no_idle = 1'b0;

    step_core_scoreboard sb = new();

    mini_mips16_step_core_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #CLK_HALF clk = ~clk;

    // Result side. Handshakes are sampled at the rising edge, which sees the values
    // from before the edge because the core and this bench both drive through
    // nonblocking assignments. Unless no_idle is set, tready drops with a chance of 7 percent.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Presents one request and holds it until the core takes it. tvalid is left
    // high on return so that back-to-back requests never toggle it within one
    // time step; the next call, or a drain, decides whether it goes low.
    task automatic send_request(input logic [2:0] cmd, input logic [7:0] addr,
                                input logic [31:0] val);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {val, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(cmd, addr, val);
    endtask

    // Stops sending and waits until every owed result has arrived, then lets the
    // pipeline settle.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // Only called while the core is idle.
    task automatic write_program_length(input logic [7:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.program_length = len;
    endtask

    // Random instruction biased toward the decoded opcodes. Jump targets mostly
    // land inside the loaded program, now and then anywhere in the pc range.
    function automatic logic [15:0] make_instr(input logic [7:0] len);
        int unsigned pick;
        logic [3:0]  op;
        logic [11:0] target;
        pick = $urandom_range(99);
        if (pick < 30)
            op = OP_RTYPE;
        else if (pick < 44)
            op = OP_ADDI;
        else if (pick < 56)
            op = OP_LW;
        else if (pick < 68)
            op = OP_SW;
        else if (pick < 78)
            op = OP_BEQ;
        else if (pick < 86)
            op = OP_JUMP;
        else
            op = 4'($urandom());
        if (op == OP_JUMP)
        begin
            if (len == 0 || $urandom_range(9) == 0)
                target = 12'($urandom());
            else
                target = 12'($urandom_range(len - 1));
            return {op, target};
        end
        return {op, 12'($urandom())};
    endfunction

    // A step never fetches a program word that was never written: when the pc
    // points at such a word inside the program, a random instruction is loaded
    // there first.
    task automatic issue_step();
        logic [31:0] v;
        if (sb.pc < sb.program_length && sb.pc < TB_PROG_DEPTH && !sb.program_loaded[sb.pc])
        begin
            v       = $urandom();
            v[15:0] = make_instr(sb.program_length);
            send_request(CMD_WR_PROG, sb.pc[7:0], v);
        end
        send_request(CMD_STEP, 8'($urandom()), $urandom());
    endtask

    // Run ceiling, far above the slowest correct run.
    initial
    begin
        #TIMEOUT_NS;
        $display("mini_mips16_step_core_top regression: fail");
        $finish;
    end

    initial
    begin
        int          phase;
        int          random_count;
        int          quota;
        int          n;
        int unsigned pick;
        logic [7:0]  len;
        logic [7:0]  addr;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With a zero program length a step only reports the end,
        // and a back before any executed step leaves the pc alone.
        write_program_length(8'd0);
        issue_step();
        send_request(CMD_BACK, 8'($urandom()), $urandom());
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            send_request(3'(c), 8'($urandom()), $urandom());
        // Program write just past the store is dropped.
        send_request(CMD_WR_PROG, 8'(TB_PROG_DEPTH), $urandom());
        send_request(CMD_WR_DATA, 8'd126, 32'h8000_0000);
        wait_results_drained();

        // Load and run the directed program: every operation, wrapping arithmetic,
        // a wrapped data address, a taken branch and a jump out of the program.
        write_program_length(8'd16);
        foreach (DEMO_PROGRAM[i])
            send_request(CMD_WR_PROG, 8'(i), {16'($urandom()), DEMO_PROGRAM[i]});
        repeat (12) issue_step();
        send_request(CMD_BACK, 8'($urandom()), $urandom());
        send_request(CMD_PC_RESET, 8'($urandom()), $urandom());

        // Random part, in phases that each run with one program length. Most
        // requests are steps through a program that fills in as it runs; the rest
        // are data writes, stray program writes, backs, pc resets and ignored
        // commands. The second phase runs without any idle cycles.
        phase        = 0;
        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            if (phase < $size(PRESET_LENGTHS))
                len = PRESET_LENGTHS[phase];
            else
                len = 8'($urandom_range(32, 1));
            wait_results_drained();
            no_idle = (phase == 1);
            write_program_length(len);
            quota = (len == 0) ? 15 : PHASE_ITEMS;
            n     = 0;
            while (n < quota)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    // Stuck at the end of the program: restart half of the time.
                    if (sb.pc >= sb.program_length && $urandom_range(1) == 1)
                        send_request(CMD_PC_RESET, 8'($urandom()), $urandom());
                    else
                        issue_step();
                    n++;
                end
                else if (pick < 80)
                begin
                    send_request(CMD_WR_DATA, 8'($urandom()), $urandom());
                    n++;
                end
                else if (pick < 85)
                begin
                    addr = 8'($urandom());
                    send_request(CMD_WR_PROG, addr, $urandom());
                    if (addr < TB_PROG_DEPTH)
                        n++;
                end
                else if (pick < 91)
                begin
                    send_request(CMD_BACK, 8'($urandom()), $urandom());
                    n++;
                end
                else if (pick < 96)
                begin
                    send_request(CMD_PC_RESET, 8'($urandom()), $urandom());
                    n++;
                end
                else if (pick < 99)
                    send_request(3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)),
                                 8'($urandom()), $urandom());
                else
                    // Hold off until the core has delivered everything owed.
                    wait_results_drained();
            end
            random_count += quota;
            phase++;
        end

        no_idle = 1'b0;
        wait_results_drained();
        if (sb.errors == 0)
            $display("mini_mips16_step_core_top regression: pass");
        else
            $display("mini_mips16_step_core_top regression: fail");
        $finish;
    end

endmodule
